// ===== sv/evcp_pkg.sv =====
// Shared types and constants for the EV charge pilot controller.
package evcp_pkg;

   localparam int unsigned ADC_W    = 10;
   localparam int unsigned SETTLE_W = 8;
   localparam int unsigned PHASE_W  = 14;
   localparam int unsigned TICKS_W  = 13;
   localparam int unsigned AMPS_W   = 5;
   localparam int unsigned DUTY_W   = 7;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;

   localparam int unsigned AMPS_BASE = 16;
   localparam int unsigned AMPS_PEAK = 29;
   localparam int unsigned DUTY_BASE = AMPS_BASE * 5 / 3;
   localparam int unsigned DUTY_PEAK = AMPS_PEAK * 5 / 3;

   localparam logic [ADC_W-1:0]    THR_NO_VEHICLE_RST = ADC_W'(915);
   localparam logic [ADC_W-1:0]    THR_CONNECTED_RST  = ADC_W'(800);
   localparam logic [ADC_W-1:0]    THR_CHARGE_RST     = ADC_W'(700);
   localparam logic [ADC_W-1:0]    THR_VENT_RST       = ADC_W'(600);
   localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST   = SETTLE_W'(200);
   localparam logic [TICKS_W-1:0]  PEAK_TICKS_RST     = TICKS_W'(1500);
   localparam logic [TICKS_W-1:0]  COOLDOWN_TICKS_RST = TICKS_W'(6000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THR_NO_VEHICLE = 3'd0,
      CSR_THR_CONNECTED  = 3'd1,
      CSR_THR_CHARGE     = 3'd2,
      CSR_THR_VENT       = 3'd3,
      CSR_SETTLE_TICKS   = 3'd4,
      CSR_PEAK_TICKS     = 3'd5,
      CSR_COOLDOWN_TICKS = 3'd6,
      CSR_VENT_OK        = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_UNPLUGGED   = 4'd0,
      ST_IDLE        = 4'd1,
      ST_CHARGING    = 4'd2,
      ST_VENT_NEEDED = 4'd3,
      ST_VENT_CHARGE = 4'd4,
      ST_NO_AC       = 4'd5,
      ST_RELAY_OPEN  = 4'd6,
      ST_RELAY_STUCK = 4'd7,
      ST_PILOT_FAULT = 4'd8
   } status_type;

   typedef struct packed {
      logic [ADC_W-1:0]    thr_no_vehicle;
      logic [ADC_W-1:0]    thr_connected;
      logic [ADC_W-1:0]    thr_charge;
      logic [ADC_W-1:0]    thr_vent;
      logic [SETTLE_W-1:0] settle_ticks;
      logic [TICKS_W-1:0]  peak_ticks;
      logic [TICKS_W-1:0]  cooldown_ticks;
      logic                vent_ok;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic       relay_drive;
   } pilot_result_type;

endpackage

// ===== sv/evcp_csr.sv =====
// Configuration register file for the charge pilot controller.
module evcp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [evcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [evcp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output evcp_pkg::cfg_type                 cfg
);
   import evcp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_THR_NO_VEHICLE: cfg_in.thr_no_vehicle = csr_wdata[ADC_W-1:0];
            CSR_THR_CONNECTED:  cfg_in.thr_connected  = csr_wdata[ADC_W-1:0];
            CSR_THR_CHARGE:     cfg_in.thr_charge     = csr_wdata[ADC_W-1:0];
            CSR_THR_VENT:       cfg_in.thr_vent       = csr_wdata[ADC_W-1:0];
            CSR_SETTLE_TICKS:   cfg_in.settle_ticks   = csr_wdata[SETTLE_W-1:0];
            CSR_PEAK_TICKS:     cfg_in.peak_ticks     = csr_wdata[TICKS_W-1:0];
            CSR_COOLDOWN_TICKS: cfg_in.cooldown_ticks = csr_wdata[TICKS_W-1:0];
            CSR_VENT_OK:        cfg_in.vent_ok        = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_no_vehicle <= THR_NO_VEHICLE_RST;
         cfg_ff.thr_connected  <= THR_CONNECTED_RST;
         cfg_ff.thr_charge     <= THR_CHARGE_RST;
         cfg_ff.thr_vent       <= THR_VENT_RST;
         cfg_ff.settle_ticks   <= SETTLE_TICKS_RST;
         cfg_ff.peak_ticks     <= PEAK_TICKS_RST;
         cfg_ff.cooldown_ticks <= COOLDOWN_TICKS_RST;
         cfg_ff.vent_ok        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/evcp_phase_timer.sv =====
// Alternating cooldown / peak phase timer that sets the offered current.
module evcp_phase_timer (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  evcp_pkg::cfg_type cfg,
   output logic              peak_next
);
   import evcp_pkg::*;

   logic               in_peak_ff;
   logic               in_peak_in;
   logic [PHASE_W-1:0] phase_count_ff;
   logic [PHASE_W-1:0] phase_count_in;
   logic [PHASE_W-1:0] limit;

   assign limit     = in_peak_ff ? PHASE_W'(cfg.peak_ticks) : PHASE_W'(cfg.cooldown_ticks);
   assign peak_next = in_peak_in;

   always_comb begin
      if (phase_count_ff <= limit) begin
         phase_count_in = phase_count_ff + PHASE_W'(1);
         in_peak_in     = in_peak_ff;
      end else begin
         phase_count_in = '0;
         in_peak_in     = ~in_peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_peak_ff     <= 1'b0;
         phase_count_ff <= '0;
      end else if (advance) begin
         in_peak_ff     <= in_peak_in;
         phase_count_ff <= phase_count_in;
      end
   end

endmodule

// ===== sv/evcp_pilot_ctrl.sv =====
// Pilot level classification, relay drive, settle timer and fault latching.
module evcp_pilot_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  evcp_pkg::cfg_type             cfg,
   input  logic [evcp_pkg::ADC_W-1:0]    adc_reading,
   input  logic                          ac_present,
   input  logic                          relay_closed_sense,
   output evcp_pkg::pilot_result_type    result
);
   import evcp_pkg::*;

   logic                relay_on_ff;
   logic                relay_on_in;
   logic                settle_active_ff;
   logic                settle_active_in;
   logic [SETTLE_W-1:0] settle_count_ff;
   logic [SETTLE_W-1:0] settle_count_in;
   logic                lockout_ff;
   logic                lockout_in;
   status_type          status;

   always_comb begin
      settle_active_in = settle_active_ff;
      settle_count_in  = settle_count_ff;
      relay_on_in      = relay_on_ff;
      lockout_in       = lockout_ff;
      status           = ST_UNPLUGGED;

      if (settle_active_ff) begin
         if (settle_count_ff < cfg.settle_ticks) begin
            settle_count_in = settle_count_ff + SETTLE_W'(1);
         end else begin
            settle_count_in  = '0;
            settle_active_in = 1'b0;
         end
      end

      if (lockout_ff) begin
         status = ST_RELAY_STUCK;
      end else if (!ac_present) begin
         if (relay_on_in) begin
            relay_on_in = 1'b0; settle_count_in = '0; settle_active_in = 1'b1;
         end
         status = ST_NO_AC;
      end else if (adc_reading > cfg.thr_no_vehicle || adc_reading > cfg.thr_connected) begin
         if (relay_on_in) begin
            relay_on_in = 1'b0; settle_count_in = '0; settle_active_in = 1'b1;
         end
         if (relay_closed_sense && !settle_active_in) begin
            status     = ST_RELAY_STUCK;
            lockout_in = 1'b1;
         end else if (adc_reading > cfg.thr_no_vehicle) begin
            status = ST_UNPLUGGED;
         end else begin
            status = ST_IDLE;
         end
      end else if (adc_reading > cfg.thr_charge ||
                   (adc_reading > cfg.thr_vent && cfg.vent_ok)) begin
         if (!relay_on_in) begin
            relay_on_in = 1'b1; settle_count_in = '0; settle_active_in = 1'b1;
         end
         status = (adc_reading > cfg.thr_charge) ? ST_CHARGING : ST_VENT_CHARGE;
         if (!relay_closed_sense && !settle_active_in) begin
            status = ST_RELAY_OPEN;
            relay_on_in = 1'b0; settle_count_in = '0; settle_active_in = 1'b1;
         end
      end else begin
         if (relay_on_in) begin
            relay_on_in = 1'b0; settle_count_in = '0; settle_active_in = 1'b1;
         end
         status = (adc_reading > cfg.thr_vent) ? ST_VENT_NEEDED : ST_PILOT_FAULT;
      end
   end

   assign result.status      = status;
   assign result.relay_drive = relay_on_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_on_ff      <= 1'b0;
         settle_active_ff <= 1'b0;
         settle_count_ff  <= '0;
         lockout_ff       <= 1'b0;
      end else if (advance) begin
         relay_on_ff      <= relay_on_in;
         settle_active_ff <= settle_active_in;
         settle_count_ff  <= settle_count_in;
         lockout_ff       <= lockout_in;
      end
   end

endmodule

// ===== sv/ev_charge_pilot_controller.sv =====
// Top level of the EV charge pilot controller.
//
// Feed one req_ beat per 1 ms tick: the pilot ADC sample, AC-present and
// relay-closed sense. Each accepted beat yields exactly one rsp_ beat with
// the status code, the relay command, the offered current (16 A base or
// 29 A peak), the pilot PWM duty and the peak phase flag.
// An accepted beat is registered and shows on rsp_ in the next cycle.
// Throughput is one beat per cycle while req_stall is low; the per-tick
// update is a single pass through the settle timer, phase timer and threshold
// classifier between the accepted request and the result register.
// req_stall rises only while a result is held and rsp_stall is high; the
// result register then keeps its beat, and the next request is taken in
// the same cycle the held result leaves.
// The csr_ port writes thresholds and timer lengths; it is always ready and
// should be written while no tick is in flight.
// Synchronous reset restores all register defaults, opens the relay, clears
// both timers and the stuck-relay lockout, and empties the result register.
module ev_charge_pilot_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [evcp_pkg::ADC_W-1:0]          req_adc_reading,
   input  logic                                req_ac_present,
   input  logic                                req_relay_closed_sense,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_status,
   output logic                                rsp_relay_drive,
   output logic [evcp_pkg::AMPS_W-1:0]         rsp_current_limit,
   output logic [evcp_pkg::DUTY_W-1:0]         rsp_duty_percent,
   output logic                                rsp_peak_phase,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [evcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [evcp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import evcp_pkg::*;

   cfg_type          cfg;
   pilot_result_type result;
   logic             advance;
   logic             peak_next;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [3:0]        status_ff;
   logic              relay_drive_ff;
   logic              peak_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign advance   = req_valid & ~req_stall;

   evcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   evcp_phase_timer u_phase (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .peak_next (peak_next)
   );

   evcp_pilot_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .cfg                (cfg),
      .adc_reading        (req_adc_reading),
      .ac_present         (req_ac_present),
      .relay_closed_sense (req_relay_closed_sense),
      .result             (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff      <= result.status;
         relay_drive_ff <= result.relay_drive;
         peak_ff        <= peak_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_relay_drive   = relay_drive_ff;
   assign rsp_peak_phase    = peak_ff;
   assign rsp_current_limit = peak_ff ? AMPS_W'(AMPS_PEAK) : AMPS_W'(AMPS_BASE);
   assign rsp_duty_percent  = peak_ff ? DUTY_W'(DUTY_PEAK) : DUTY_W'(DUTY_BASE);

endmodule

// ===== sv/evcp_checker.sv =====
// Port-level checker for the charge pilot controller, bound to the top level.
module evcp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [3:0]                  rsp_status,
   input logic                        rsp_relay_drive,
   input logic [evcp_pkg::AMPS_W-1:0] rsp_current_limit,
   input logic [evcp_pkg::DUTY_W-1:0] rsp_duty_percent,
   input logic                        rsp_peak_phase
);
   import evcp_pkg::*;

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   a_held_beat_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_relay_drive) && $stable(rsp_peak_phase)))
      else $error("stalled result beat changed");

   a_phase_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_peak_phase && rsp_current_limit == AMPS_W'(AMPS_PEAK) &&
                      rsp_duty_percent == DUTY_W'(DUTY_PEAK)) ||
                     (!rsp_peak_phase && rsp_current_limit == AMPS_W'(AMPS_BASE) &&
                      rsp_duty_percent == DUTY_W'(DUTY_BASE))))
      else $error("current limit, duty and phase disagree");

   a_relay_only_charging: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_relay_drive) |-> (rsp_status == ST_CHARGING ||
                                          rsp_status == ST_VENT_CHARGE))
      else $error("relay closed outside a charging status");

   a_stuck_latches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RELAY_STUCK) |=>
         !(rsp_valid && rsp_status != ST_RELAY_STUCK))
      else $error("stuck relay lockout released");

endmodule

bind ev_charge_pilot_controller evcp_checker u_evcp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_relay_drive   (rsp_relay_drive),
   .rsp_current_limit (rsp_current_limit),
   .rsp_duty_percent  (rsp_duty_percent),
   .rsp_peak_phase    (rsp_peak_phase)
);
